FILE: rtl/core/sroc_pkg.sv
`default_nettype none

package sroc_pkg;

    // Field widths of one item.
    localparam int TEMP_W = 16;
    localparam int HUM_W  = 14;
    localparam int CODE_W = 10;
    localparam int MV_W   = 16;
    localparam int TDB_W  = 15;
    localparam int SCALE_W = 16;
    localparam int PROD_W = CODE_W + SCALE_W;
    localparam int FRAC_W = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_DEADBAND = 2'd0,
        CFG_HUM_DEADBAND  = 2'd1,
        CFG_BATT_SCALE    = 2'd2,
        CFG_BATT_JUMP     = 2'd3
    } t_cfg_idx;

    // Configuration reset values.
    localparam logic [TDB_W-1:0]   TEMP_DB_RST    = 15'd50;
    localparam logic [HUM_W-1:0]   HUM_DB_RST     = 14'd100;
    localparam logic [SCALE_W-1:0] BATT_SCALE_RST = 16'd1051;
    localparam logic [MV_W-1:0]    BATT_JUMP_RST  = 16'd150;

    typedef enum logic [1:0] {
        ACT_SKIP    = 2'd0,
        ACT_TX      = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi_f;
        logic [HUM_W-1:0]         hum_centi_pct;
        logic [CODE_W-1:0]        battery_code;
        logic                     sensor_failed;
    } t_in_item;

    typedef struct packed {
        t_action                  action;
        logic [MV_W-1:0]          battery_mv;
        logic signed [TEMP_W-1:0] temp_out;
        logic [HUM_W-1:0]         hum_out;
    } t_out_item;

    typedef struct packed {
        logic [TDB_W-1:0]   temp_deadband;
        logic [HUM_W-1:0]   hum_deadband;
        logic [SCALE_W-1:0] battery_scale_q8;
        logic [MV_W-1:0]    battery_jump_limit_mv;
    } t_cfg;

    // Sample after the scaling stage.
    typedef struct packed {
        t_in_item        item;
        logic [MV_W-1:0] mv;
    } t_scaled;

    // Scale an ADC code to millivolts, Q8 scale, saturating.
    function automatic logic [MV_W-1:0] scale_mv(input logic [CODE_W-1:0] code,
                                                 input logic [SCALE_W-1:0] scale);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-FRAC_W-1:0] whole;
        prod  = PROD_W'(code) * PROD_W'(scale);
        whole = prod[PROD_W-1:FRAC_W];
        if (whole[PROD_W-FRAC_W-1:MV_W] != '0) begin
            return '1;
        end
        return whole[MV_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sroc_cfg_regs.sv
`default_nettype none

module sroc_cfg_regs
    import sroc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MV_W-1:0]      i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file, written one register per handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_deadband         <= TEMP_DB_RST;
            r_cfg.hum_deadband          <= HUM_DB_RST;
            r_cfg.battery_scale_q8      <= BATT_SCALE_RST;
            r_cfg.battery_jump_limit_mv <= BATT_JUMP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_DEADBAND: r_cfg.temp_deadband <= i_cfg_data[TDB_W-1:0];
                CFG_HUM_DEADBAND:  r_cfg.hum_deadband  <= i_cfg_data[HUM_W-1:0];
                CFG_BATT_SCALE:    r_cfg.battery_scale_q8 <= i_cfg_data;
                CFG_BATT_JUMP:     r_cfg.battery_jump_limit_mv <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sroc_decide.sv
`default_nettype none

module sroc_decide
    import sroc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_adv,
    input  wire t_scaled i_smp,
    input  wire t_cfg    i_cfg,
    output t_out_item    o_res
);

    logic                     r_record_valid;
    logic                     r_restart_flag;
    logic signed [TEMP_W-1:0] r_last_temp;
    logic [HUM_W-1:0]         r_last_hum;
    logic [CODE_W-1:0]        r_last_code;
    logic [MV_W-1:0]          r_last_mv;

    logic [MV_W-1:0]          jump;
    logic                     jump_hit;
    logic signed [TEMP_W:0]   tdiff;
    logic [TEMP_W:0]          dt;
    logic [HUM_W-1:0]         dh;
    logic                     quiet;
    logic                     failed;
    logic                     store;

    assign failed = i_smp.item.sensor_failed;

    // Battery jump against the stored record.
    always_comb begin
        if (i_smp.mv >= r_last_mv) begin
            jump = i_smp.mv - r_last_mv;
        end else begin
            jump = r_last_mv - i_smp.mv;
        end
        jump_hit = r_record_valid && !r_restart_flag && (jump > i_cfg.battery_jump_limit_mv);
    end

    // Deadband test on temperature, humidity and the raw code.
    always_comb begin
        tdiff = (TEMP_W+1)'(i_smp.item.temp_centi_f) - (TEMP_W+1)'(r_last_temp);
        if (tdiff[TEMP_W]) begin
            dt = (~tdiff) + (TEMP_W+1)'(1);
        end else begin
            dt = tdiff;
        end
        if (i_smp.item.hum_centi_pct >= r_last_hum) begin
            dh = i_smp.item.hum_centi_pct - r_last_hum;
        end else begin
            dh = r_last_hum - i_smp.item.hum_centi_pct;
        end
        quiet = (i_smp.item.battery_code == r_last_code)
             && (dt < (TEMP_W+1)'(i_cfg.temp_deadband))
             && (dh < i_cfg.hum_deadband);
    end

    // Result item.
    always_comb begin
        if (failed) begin
            o_res.action     = ACT_RESTART;
            o_res.battery_mv = '0;
            o_res.temp_out   = '0;
            o_res.hum_out    = '0;
        end else begin
            o_res.battery_mv = i_smp.mv;
            o_res.temp_out   = i_smp.item.temp_centi_f;
            o_res.hum_out    = i_smp.item.hum_centi_pct;
            if (jump_hit) begin
                o_res.action = ACT_RESTART;
            end else if (r_record_valid && quiet) begin
                o_res.action = ACT_SKIP;
            end else begin
                o_res.action = ACT_TX;
            end
        end
    end

    assign store = i_adv && !failed && !jump_hit && (o_res.action == ACT_TX);

    // Stored record and restart flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_valid <= 1'b0;
            r_restart_flag <= 1'b0;
            r_last_temp    <= '0;
            r_last_hum     <= '0;
            r_last_code    <= '0;
        end else if (i_adv && !failed) begin
            if (r_record_valid) begin
                r_restart_flag <= jump_hit;
            end
            if (store) begin
                r_record_valid <= 1'b1;
                r_last_temp    <= i_smp.item.temp_centi_f;
                r_last_hum     <= i_smp.item.hum_centi_pct;
                r_last_code    <= i_smp.item.battery_code;
            end
        end
    end

    // Stored millivolts follow the stored code under the current scale.
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_last_mv <= i_smp.mv;
        end else begin
            r_last_mv <= scale_mv(r_last_code, i_cfg.battery_scale_q8);
        end
    end

`ifndef SYNTHESIS
    a_jump_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !failed && jump_hit) |=> r_restart_flag)
        else $error("battery jump did not set the restart flag");

    a_tx_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.action == ACT_TX) |=> (r_record_valid && !r_restart_flag))
        else $error("transmit did not leave a valid record");

    a_fail_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && failed) |=> ($stable(r_restart_flag) && $stable(r_record_valid)
                               && $stable(r_last_code)))
        else $error("sensor failure changed the stored record");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sensor_report_on_change_filter.sv
`default_nettype none

// An item passes the input, scaling and result registers. Throughput: one
// item per cycle unless i_stall holds the output; the record is updated in
// the decision stage, so each item sees the record left by the item before it.
// Reset (synchronous, active low) empties the pipeline, clears the record
// and restart flag, and loads the configuration registers with their defaults.
module sensor_report_on_change_filter
    import sroc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in_item             i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out_item                 o_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MV_W-1:0]      i_cfg_data
);

    t_cfg      cfg;
    logic      r_in_v;
    t_in_item  r_in;
    logic      r_s1_v;
    t_scaled   r_s1;
    logic      r_out_v;
    t_out_item r_out;
    t_out_item res;
    logic      out_rdy;
    logic      s1_rdy;
    logic      in_rdy;

    sroc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Each stage moves when the stage after it is empty or moving.
    assign out_rdy = !r_out_v || !i_stall;
    assign s1_rdy  = !r_s1_v || out_rdy;
    assign in_rdy  = !r_in_v || s1_rdy;
    assign o_stall = !in_rdy;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_rdy) begin
                r_in_v <= i_valid;
            end
            if (s1_rdy) begin
                r_s1_v <= r_in_v;
            end
            if (out_rdy) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    // Input register and scaling stage.
    always_ff @(posedge i_clk) begin
        if (in_rdy && i_valid) begin
            r_in <= i_data;
        end
        if (s1_rdy && r_in_v) begin
            r_s1.item <= r_in;
            r_s1.mv   <= scale_mv(r_in.battery_code, cfg.battery_scale_q8);
        end
    end

    sroc_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (r_s1_v && out_rdy),
        .i_smp   (r_s1),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (out_rdy && r_s1_v) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

FILE: tb/tb_sensor_report_on_change_filter.sv
`timescale 1ns / 1ps

module tb_sensor_report_on_change_filter;
    import sroc_pkg::*;

    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 300;
    localparam int NUM_SETTINGS   = 6;

    // DUT connections; the inputs are at known values from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_in_item             i_data      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_out_item            o_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [MV_W-1:0]      i_cfg_data  = '0;

    sensor_report_on_change_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Filter state as the testbench expects it.
    logic [TDB_W-1:0]   exp_temp_db  = TEMP_DB_RST;
    logic [HUM_W-1:0]   exp_hum_db   = HUM_DB_RST;
    logic [SCALE_W-1:0] exp_scale    = BATT_SCALE_RST;
    logic [MV_W-1:0]    exp_jump_lim = BATT_JUMP_RST;
    logic               rec_valid       = 1'b0;
    logic               restart_pending = 1'b0;
    logic signed [TEMP_W-1:0] rec_temp  = '0;
    logic [HUM_W-1:0]   rec_hum         = '0;
    logic [CODE_W-1:0]  rec_code        = '0;

    t_in_item  pending_samples[$];
    t_out_item expected_reports[$];

    int samples_issued   = 0;
    int reports_checked  = 0;
    int mismatches       = 0;
    int n_tx             = 0;
    int n_skip           = 0;
    int n_restart        = 0;
    int n_holds          = 0;
    int n_settings       = 0;
    int idle_cycles      = 0;

    // Random walk that keeps most random samples close to the stored record.
    int walk_temp = 7000;
    int walk_hum  = 5000;
    int walk_code = 800;

    // Receiver hold-off request, raised by the sequencer at a falling edge.
    logic hold_trigger = 1'b0;

    // Battery code to millivolts with the current scale, saturated to 16 bits.
    function automatic logic [MV_W-1:0] to_millivolts(input logic [CODE_W-1:0] code);
        logic [31:0] prod;
        prod = (32'(code) * 32'(exp_scale)) >> 8;
        return (prod > 32'h0000_FFFF) ? 16'hFFFF : prod[15:0];
    endfunction

    // Decide skip, transmit or restart for one sample and update the record.
    function automatic t_out_item filter_sample(input t_in_item s);
        t_out_item r;
        logic [MV_W-1:0] mv;
        logic [MV_W-1:0] old_mv;
        logic [MV_W-1:0] jump;
        int dt;
        int dh;
        r = '0;
        if (s.sensor_failed) begin
            r.action = ACT_RESTART;
            return r;
        end
        mv           = to_millivolts(s.battery_code);
        r.battery_mv = mv;
        r.temp_out   = s.temp_centi_f;
        r.hum_out    = s.hum_centi_pct;
        // A large battery jump is answered once with a restart.
        if (rec_valid) begin
            old_mv = to_millivolts(rec_code);
            jump   = (mv >= old_mv) ? mv - old_mv : old_mv - mv;
            if (jump > exp_jump_lim && !restart_pending) begin
                restart_pending = 1'b1;
                r.action = ACT_RESTART;
                return r;
            end
            restart_pending = 1'b0;
        end
        r.action = ACT_TX;
        if (rec_valid) begin
            dt = int'(s.temp_centi_f) - int'(rec_temp);
            dh = int'(s.hum_centi_pct) - int'(rec_hum);
            if (dt < 0) dt = -dt;
            if (dh < 0) dh = -dh;
            if (s.battery_code == rec_code && dt < int'(exp_temp_db)
                    && dh < int'(exp_hum_db))
                r.action = ACT_SKIP;
        end
        if (r.action == ACT_TX) begin
            rec_temp  = s.temp_centi_f;
            rec_hum   = s.hum_centi_pct;
            rec_code  = s.battery_code;
            rec_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Mostly slow drift around the walk, with jumps, failures and raw noise.
    function automatic t_in_item make_sample();
        t_in_item s;
        int pick;
        pick = $urandom_range(0, 99);
        s = '0;
        if (pick < 18) begin
            s.temp_centi_f  = 16'($urandom);
            s.hum_centi_pct = 14'($urandom);
            s.battery_code  = 10'($urandom);
            s.sensor_failed = (pick < 6);
            return s;
        end
        walk_temp = clamp(walk_temp + int'($urandom_range(0, 60)) - 30, -4000, 17600);
        walk_hum  = clamp(walk_hum + int'($urandom_range(0, 120)) - 60, 0, 10000);
        if (pick < 26)
            walk_code = $urandom_range(0, 1023);
        else if ($urandom_range(0, 9) < 2)
            walk_code = clamp(walk_code + int'($urandom_range(0, 8)) - 4, 0, 1023);
        s.temp_centi_f  = 16'(walk_temp);
        s.hum_centi_pct = 14'(walk_hum);
        s.battery_code  = 10'(walk_code);
        return s;
    endfunction

    task automatic add_sample(input int temp, input int hum, input int code, input bit failed);
        t_in_item s;
        s.temp_centi_f  = 16'(temp);
        s.hum_centi_pct = 14'(hum);
        s.battery_code  = 10'(code);
        s.sensor_failed = failed;
        pending_samples.push_back(s);
        samples_issued++;
    endtask

    // One register write; the expected configuration follows the handshake.
    task automatic write_reg(input t_cfg_idx idx, input logic [MV_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TEMP_DEADBAND: exp_temp_db  = val[TDB_W-1:0];
            CFG_HUM_DEADBAND:  exp_hum_db   = val[HUM_W-1:0];
            CFG_BATT_SCALE:    exp_scale    = val;
            CFG_BATT_JUMP:     exp_jump_lim = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] tdb, input logic [15:0] hdb,
                                 input logic [15:0] scale, input logic [15:0] jump);
        write_reg(CFG_TEMP_DEADBAND, tdb);
        write_reg(CFG_HUM_DEADBAND, hdb);
        write_reg(CFG_BATT_SCALE, scale);
        write_reg(CFG_BATT_JUMP, jump);
        n_settings++;
    endtask

    // Every sample gives one report, so the block is idle once counts match.
    task automatic wait_drained();
        do @(negedge i_clk); while (reports_checked != samples_issued);
    endtask

    task automatic log_mismatch(input string what, input t_out_item want, input t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected action=%0d mv=%0d temp=%0d hum=%0d, %s",
                     $realtime, what, want.action, want.battery_mv, want.temp_out,
                     want.hum_out,
                     $sformatf("got action=%0d mv=%0d temp=%0d hum=%0d",
                               got.action, got.battery_mv, got.temp_out, got.hum_out));
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_valid && !o_stall)
                expected_reports.push_back(filter_sample(i_data));
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data  <= pending_samples.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern changes per segment, plus long hold-offs on request.
    int hold_left  = 0;
    int seg_left   = 0;
    int stall_mode = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            n_holds++;
            i_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                seg_left   = $urandom_range(10, 80);
            end
            seg_left--;
            stall_tick++;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= (stall_tick % 4 == 3);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Check each accepted report against the oldest expectation.
    t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                log_mismatch("report with no sample pending", '0, o_data);
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (o_data.action !== want.action || o_data.battery_mv !== want.battery_mv ||
                    o_data.temp_out !== want.temp_out || o_data.hum_out !== want.hum_out)
                    log_mismatch("report mismatch", want, o_data);
                case (want.action)
                    ACT_TX:   n_tx++;
                    ACT_SKIP: n_skip++;
                    default:  n_restart++;
                endcase
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d reports outstanding",
                     WATCHDOG_LIMIT, samples_issued - reports_checked);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sequencer: directed samples at reset settings, then random sets.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Failure with no record, extreme fields.
        add_sample(32767, 16383, 1023, 1'b1);
        // First sample always transmits, then deadband edges.
        add_sample(-4000, 0, 900, 1'b0);
        add_sample(-4000, 0, 900, 1'b0);
        add_sample(-3951, 0, 900, 1'b0);
        add_sample(-3950, 0, 900, 1'b0);
        add_sample(-3950, 99, 900, 1'b0);
        add_sample(-3950, 100, 900, 1'b0);
        // Small code change transmits; a big jump restarts once.
        add_sample(-3950, 100, 901, 1'b0);
        add_sample(-3950, 100, 1000, 1'b0);
        add_sample(-3950, 100, 1000, 1'b0);
        add_sample(-3950, 100, 1000, 1'b0);
        // Failure between samples leaves the record alone.
        add_sample(0, 0, 0, 1'b1);
        add_sample(-3950, 100, 0, 1'b0);
        add_sample(-3950, 100, 0, 1'b0);
        // Deadband across zero, range ends and beyond.
        add_sample(-20, 100, 0, 1'b0);
        add_sample(29, 100, 0, 1'b0);
        add_sample(17600, 10000, 0, 1'b0);
        add_sample(-32768, 0, 0, 1'b0);
        add_sample(32767, 0, 0, 1'b0);
        // Jump just inside and just outside the limit.
        add_sample(32767, 16383, 36, 1'b0);
        add_sample(32767, 16383, 73, 1'b0);
        add_sample(-1, 0, 1023, 1'b0);
        wait_drained();

        for (int set_no = 1; set_no <= NUM_SETTINGS; set_no++) begin
            case (set_no)
                1: apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
                2: apply_setting(16'h7FFF, 16'h3FFF, 16'hFFFF, 16'hFFFF);
                3: apply_setting(16'(TEMP_DB_RST), 16'(HUM_DB_RST),
                                 BATT_SCALE_RST, BATT_JUMP_RST);
                4: apply_setting(16'($urandom_range(0, 21600)), 16'($urandom_range(0, 10000)),
                                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                5: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                default: apply_setting(16'd200, 16'd300, 16'($urandom_range(256, 2048)),
                                       16'($urandom_range(0, 400)));
            endcase
            @(negedge i_clk);
            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                pending_samples.push_back(make_sample());
                samples_issued++;
            end
            // Hold the output while the sender keeps offering, so the input backs up.
            if (set_no == 3 || set_no == 5)
                hold_trigger = 1'b1;
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (expected_reports.size() != 0)
            mismatches++;

        $display("Checked %0d reports over %0d register settings: %0d transmit, %0d skip, %s",
                 reports_checked, n_settings + 1, n_tx, n_skip,
                 $sformatf("%0d restart.", n_restart));
        $display("Receiver hold-offs: %0d, mismatches: %0d.", n_holds, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
